// File: design/rvx_pkg.sv
// Shared types and codes for the RV32IM integer execute block.
// Holds the function codes and the beat carried along the divider chain.
// Used by rvx_prep, rvx_div_cell and rv32im_integer_execute_top.
package rvx_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned DIV_CELLS = XLEN;

  localparam logic [6:0] F7_BASE   = 7'b000_0000;
  localparam logic [6:0] F7_MULDIV = 7'b000_0001;
  localparam logic [6:0] F7_ALT    = 7'b010_0000;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  localparam logic        OP_REG = 1'b0;
  localparam logic        OP_IMM = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              use_div;
    logic              take_rem;
    logic              neg_res;
    logic              invalid;
    logic [XLEN-1:0]   value;
    logic [XLEN-1:0]   rem;
    logic [XLEN-1:0]   quo;
    logic [XLEN-1:0]   dvsr;
  } beat_t;

endpackage

// File: design/rvx_prep.sv
// Entry stage: decodes the encoding, computes add, subtract, logic, shift, compare and multiply results,
// and loads the divider operands into the first beat of the chain.
// Depends on rvx_pkg.
module rvx_prep (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic                       op,
  input  logic [2:0]                 funct3,
  input  logic [6:0]                 funct7,
  input  logic [rvx_pkg::XLEN-1:0]   src_a,
  input  logic [rvx_pkg::XLEN-1:0]   src_b,
  input  logic [11:0]                imm12,
  output rvx_pkg::beat_t             beat
);

  logic [31:0]        se;
  logic [6:0]         upper;
  logic [4:0]         sh;
  logic [31:0]        opb;
  logic               ok;
  logic [31:0]        value;
  logic               is_div;
  logic               sgn_div;
  logic               sa;
  logic               sb;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  rvx_pkg::beat_t     beat_next;

  always_comb begin
    se    = {{20{imm12[11]}}, imm12};
    upper = imm12[11:5];
    opb   = (op == rvx_pkg::OP_IMM) ? se : src_b;
    sh    = (op == rvx_pkg::OP_IMM) ? imm12[4:0] : src_b[4:0];
    sa    = (funct3 == rvx_pkg::F3_MULH) || (funct3 == rvx_pkg::F3_MULHSU);
    sb    = (funct3 == rvx_pkg::F3_MULH);
    ma    = $signed({sa & src_a[31], src_a});
    mb    = $signed({sb & src_b[31], src_b});
    prod  = ma * mb;
    ok    = 1'b1;
    value = '0;
    is_div = 1'b0;
    if ((op == rvx_pkg::OP_REG) && (funct7 == rvx_pkg::F7_MULDIV)) begin
      unique case (funct3) inside
        rvx_pkg::F3_MUL:                     value = prod[31:0];
        rvx_pkg::F3_MULH, rvx_pkg::F3_MULHSU,
        rvx_pkg::F3_MULHU:                   value = prod[63:32];
        default: begin
          if (src_b == '0) begin
            value = funct3[1] ? src_a : '1;
          end else begin
            is_div = 1'b1;
          end
        end
      endcase
    end else begin
      unique case (funct3)
        rvx_pkg::F3_ADD: begin
          if ((op == rvx_pkg::OP_REG) && (funct7 == rvx_pkg::F7_ALT)) begin
            value = src_a - src_b;
          end else begin
            value = src_a + opb;
          end
        end
        rvx_pkg::F3_SLL:  value = src_a << sh;
        rvx_pkg::F3_SLT:  value = {31'd0, $signed(src_a) < $signed(opb)};
        rvx_pkg::F3_SLTU: value = {31'd0, src_a < opb};
        rvx_pkg::F3_XOR:  value = src_a ^ opb;
        rvx_pkg::F3_SRL: begin
          if (((op == rvx_pkg::OP_IMM) && (upper == rvx_pkg::F7_ALT)) ||
              ((op == rvx_pkg::OP_REG) && (funct7 == rvx_pkg::F7_ALT))) begin
            value = $unsigned($signed(src_a) >>> sh);
          end else begin
            value = src_a >> sh;
          end
        end
        rvx_pkg::F3_OR:   value = src_a | opb;
        default:          value = src_a & opb;
      endcase
      if (op == rvx_pkg::OP_IMM) begin
        if ((funct3 == rvx_pkg::F3_SLL) && (upper != rvx_pkg::F7_BASE)) ok = 1'b0;
        if ((funct3 == rvx_pkg::F3_SRL) && (upper != rvx_pkg::F7_BASE) &&
            (upper != rvx_pkg::F7_ALT)) ok = 1'b0;
      end else if (funct7 == rvx_pkg::F7_ALT) begin
        if ((funct3 != rvx_pkg::F3_ADD) && (funct3 != rvx_pkg::F3_SRL)) ok = 1'b0;
      end else if (funct7 != rvx_pkg::F7_BASE) begin
        ok = 1'b0;
      end
    end
    sgn_div = !funct3[0];
    mag_a   = (sgn_div && src_a[31]) ? (32'd0 - src_a) : src_a;
    mag_b   = (sgn_div && src_b[31]) ? (32'd0 - src_b) : src_b;

    beat_next.valid    = take;
    beat_next.use_div  = is_div && ok;
    beat_next.take_rem = funct3[1];
    beat_next.neg_res  = sgn_div && (funct3[1] ? src_a[31] : (src_a[31] ^ src_b[31]));
    beat_next.invalid  = !ok;
    beat_next.value    = ok ? value : '0;
    beat_next.rem      = '0;
    beat_next.quo      = mag_a;
    beat_next.dvsr     = mag_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else begin
      beat <= beat_next;
    end
  end

endmodule

// File: design/rvx_div_cell.sv
// One cell of the divider chain: a single restoring division step per beat.
// Other beats pass through unchanged in meaning. Depends on rvx_pkg.
module rvx_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  rvx_pkg::beat_t beat_in,
  output rvx_pkg::beat_t beat_out
);

  logic [32:0]    trial;
  logic [32:0]    diff;
  logic           ge;
  rvx_pkg::beat_t beat_next;

  always_comb begin
    trial     = {beat_in.rem, beat_in.quo[31]};
    diff      = trial - {1'b0, beat_in.dvsr};
    ge        = !diff[32];
    beat_next = beat_in;
    beat_next.rem = ge ? diff[31:0] : trial[31:0];
    beat_next.quo = {beat_in.quo[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out <= beat_next;
    end
  end

endmodule

// File: design/rv32im_integer_execute_top.sv
// Top level of the RV32IM integer execute block: entry stage, 32 divider cells, output register.
// Depends on rvx_pkg, rvx_prep and rvx_div_cell.
// A result passes the entry register, the 32 divider cells and the output register in order;
// one beat per cycle, busy stays low. Every operation traverses the whole 32-cell divider chain.
// Synchronous reset empties the chain; the receiver cannot stall, so results never wait.
module rv32im_integer_execute_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [2:0]  funct3,
  input  logic [6:0]  funct7,
  input  logic [31:0] src_a,
  input  logic [31:0] src_b,
  input  logic [11:0] imm12,
  output logic        done,
  output logic [31:0] result,
  output logic        invalid
);

  rvx_pkg::beat_t chain [0:rvx_pkg::DIV_CELLS];
  rvx_pkg::beat_t last;
  logic [31:0]    raw;
  logic [31:0]    fixed;

  assign busy = 1'b0;

  rvx_prep u_prep (
    .clk    (clk),
    .rst    (rst),
    .take   (start && !busy),
    .op     (op),
    .funct3 (funct3),
    .funct7 (funct7),
    .src_a  (src_a),
    .src_b  (src_b),
    .imm12  (imm12),
    .beat   (chain[0])
  );

  for (genvar i = 0; i < rvx_pkg::DIV_CELLS; i++) begin : g_cell
    rvx_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  always_comb begin
    last  = chain[rvx_pkg::DIV_CELLS];
    raw   = last.take_rem ? last.rem : last.quo;
    fixed = last.neg_res ? (32'd0 - raw) : raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done    <= last.valid;
      result  <= last.use_div ? fixed : last.value;
      invalid <= last.invalid;
    end
  end

  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##34 done) else $error("result beat missing");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && invalid) |-> (result == '0)) else $error("invalid result not zero");

  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done after reset");

endmodule
